[src/bba_pkg.sv]
// Shared types and codes for the buddy block allocator.
// Depends on nothing; bba_decode and the top level import it.
package bba_pkg;

	localparam int REQ_W   = 11;
	localparam int START_W = 10;
	localparam int STAT_W  = 2;

	// node codes held in the tree store
	localparam logic [1:0] NS_ABSENT = 2'd0;
	localparam logic [1:0] NS_FREE   = 2'd1;
	localparam logic [1:0] NS_SPLIT  = 2'd2;
	localparam logic [1:0] NS_USED   = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOFIT    = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_BADSIZE  = 2'd3;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [REQ_W-1:0]   req_size;
		logic [START_W-1:0] blk_start;
		logic [REQ_W-1:0]   blk_end;
	} bba_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [START_W-1:0] granted_start;
	} bba_rsp_t;

	// position of the highest set bit of an 11-bit value
	function automatic logic [3:0] log2_11(input logic [REQ_W-1:0] v);
		logic [3:0] r;
		r = '0;
		for (int b = 0; b < REQ_W; b++) begin
			if (v[b]) r = 4'(b);
		end
		return r;
	endfunction

endpackage

[src/bba_node_ram.sv]
// Tree node store: one write port, one registered read port.
// Depends on nothing; the node code width is fixed at two bits.
module bba_node_ram #(
	parameter int DEPTH = 2047,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [1:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [1:0]    rdata
);
	logic [1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[src/bba_decode.sv]
// Request decode: size checks, tree level and node index of a request.
// Depends on bba_pkg for the request type and log2 helper.
module bba_decode #(
	parameter int TOTAL_SIZE = 1024,
	parameter int MIN_BLOCK  = 1,
	parameter int LW         = 4,
	parameter int IW         = 11
) (
	input  bba_pkg::bba_req_t req,
	output logic              ok,
	output logic [LW-1:0]     lvl,
	output logic [IW-1:0]     idx
);
	import bba_pkg::*;

	localparam int LOG_TOTAL = $clog2(TOTAL_SIZE);

	logic [REQ_W-1:0] sz;
	logic [REQ_W-1:0] blen;
	logic [3:0]       lg;
	logic             pow2;
	logic             range_ok;
	logic             free_ok;
	logic [31:0]      lvl32;
	logic [31:0]      idx32;

	assign blen = req.blk_end - {1'b0, req.blk_start};
	assign sz   = (req.cmd == CMD_ALLOC) ? req.req_size : blen;
	assign lg   = log2_11(sz);
	assign pow2 = (sz != '0) && ((sz & (sz - 1'b1)) == '0);
	assign range_ok = (32'(sz) >= 32'(MIN_BLOCK)) && (32'(sz) <= 32'(TOTAL_SIZE));

	// free also needs end above start, end in range and start aligned
	assign free_ok = (req.blk_end > {1'b0, req.blk_start})
		&& (32'(req.blk_end) <= 32'(TOTAL_SIZE))
		&& ((req.blk_start & sz[START_W-1:0] - 1'b1) == '0);

	assign ok    = pow2 && range_ok && ((req.cmd == CMD_ALLOC) || free_ok);
	assign lvl32 = 32'(LOG_TOTAL) - 32'(lg);
	assign lvl   = lvl32[LW-1:0];
	assign idx32 = ((32'd1 << lvl32) - 32'd1) + (32'(req.blk_start) >> lg);
	assign idx   = idx32[IW-1:0];
endmodule

[src/buddy_block_allocator_unit.sv]
// Buddy block allocator, top level: handshake, sequencer and result register.
// Depends on bba_pkg, bba_decode and bba_node_ram.
// After reset a clearing pass over all 2*TOTAL_SIZE/MIN_BLOCK-1 nodes sets the root free and
// every other node absent; no request is taken meanwhile. One request at a time: an
// allocate scans nodes and splits blocks down to the requested level; a free marks its node
// free, then merges with a free buddy level by level towards the root. A request that fails
// decode, or a free of an absent or split node, gets an error status. The result becomes valid
// in the same cycle that the next request can be taken; each node visit costs a store read and a check.
module buddy_block_allocator_unit #(
	parameter int TOTAL_SIZE = 1024,
	parameter int MIN_BLOCK  = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  bba_pkg::bba_req_t req_data,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output bba_pkg::bba_rsp_t rsp_data
);
	import bba_pkg::*;

	localparam int LOG_TOTAL  = $clog2(TOTAL_SIZE);
	localparam int LMAX       = $clog2(TOTAL_SIZE / MIN_BLOCK);
	localparam int NODE_COUNT = 2 * (TOTAL_SIZE / MIN_BLOCK) - 1;
	localparam int IW         = $clog2(NODE_COUNT);
	localparam int LW         = $clog2(LMAX + 1);

	typedef enum logic [16:0] {
		S_CLR   = 17'h00001,
		S_IDLE  = 17'h00002,
		S_DEC   = 17'h00004,
		S_A_RD  = 17'h00008,
		S_A_CHK = 17'h00010,
		S_A_SPL = 17'h00020,
		S_A_SPR = 17'h00040,
		S_A_USE = 17'h00080,
		S_F_RD  = 17'h00100,
		S_F_CHK = 17'h00200,
		S_F_WFR = 17'h00400,
		S_F_BRD = 17'h00800,
		S_F_BCK = 17'h01000,
		S_F_M1  = 17'h02000,
		S_F_M2  = 17'h04000,
		S_F_M3  = 17'h08000,
		S_DONE  = 17'h10000
	} state_t;

	state_t             state_q;
	bba_req_t           req_q;
	logic [IW-1:0]      idx_q;
	logic [LW-1:0]      lvl_q;
	logic [LW-1:0]      lr_q;
	logic [STAT_W-1:0]  stat_q;
	logic [START_W-1:0] start_q;
	logic               rsp_valid_q;
	bba_rsp_t           rsp_q;

	logic          dec_ok;
	logic [LW-1:0] dec_lvl;
	logic [IW-1:0] dec_idx;

	logic          we;
	logic [IW-1:0] waddr;
	logic [1:0]    wdata;
	logic [IW-1:0] raddr;
	logic [1:0]    rdata;

	logic [IW-1:0] buddy;
	logic [IW-1:0] parent;
	logic [IW-1:0] lvl_last;
	logic [IW-1:0] base_dn;
	logic [IW-1:0] lvl_base;
	logic [31:0]   start32;

	bba_decode #(
		.TOTAL_SIZE(TOTAL_SIZE),
		.MIN_BLOCK (MIN_BLOCK),
		.LW        (LW),
		.IW        (IW)
	) u_dec (
		.req(req_q),
		.ok (dec_ok),
		.lvl(dec_lvl),
		.idx(dec_idx)
	);

	bba_node_ram #(
		.DEPTH(NODE_COUNT),
		.AW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// tree navigation from the current node and level
	assign buddy    = idx_q[0] ? idx_q + 1'b1 : idx_q - 1'b1;
	assign parent   = (idx_q - 1'b1) >> 1;
	assign lvl_base = IW'((32'd1 << lvl_q) - 32'd1);
	assign lvl_last = IW'((32'd1 << (32'(lvl_q) + 32'd1)) - 32'd2);
	assign base_dn  = IW'((32'd1 << (32'(lvl_q) - 32'd1)) - 32'd1);
	// block start: offset within its level scaled by the block size
	assign start32  = 32'(idx_q - lvl_base) << (32'(LOG_TOTAL) - 32'(lvl_q));

	// store port: clearing pass, split, mark and merge writes
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = NS_ABSENT;
		raddr = idx_q;
		unique case (state_q)
			S_CLR: begin
				we    = 1'b1;
				wdata = (idx_q == '0) ? NS_FREE : NS_ABSENT;
			end
			S_A_SPL: begin
				we    = 1'b1;
				wdata = NS_SPLIT;
			end
			S_A_SPR: begin
				// upper child of the node being split
				we    = 1'b1;
				waddr = {idx_q[IW-2:0], 1'b1} + 1'b1;
				wdata = NS_FREE;
			end
			S_A_USE: begin
				we    = 1'b1;
				wdata = NS_USED;
			end
			S_F_WFR: begin
				we    = 1'b1;
				wdata = NS_FREE;
			end
			S_F_BRD: raddr = buddy;
			S_F_M1: we = 1'b1;
			S_F_M2: begin
				we    = 1'b1;
				waddr = buddy;
			end
			S_F_M3: begin
				we    = 1'b1;
				waddr = parent;
				wdata = NS_FREE;
			end
			default: ;
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					if (idx_q == IW'(NODE_COUNT - 1)) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req_data;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					start_q <= '0;
					if (!dec_ok) begin
						stat_q  <= (req_q.cmd == CMD_ALLOC) ? ST_BADSIZE : ST_NOTFOUND;
						state_q <= S_DONE;
					end else if (req_q.cmd == CMD_ALLOC) begin
						lvl_q   <= dec_lvl;
						lr_q    <= dec_lvl;
						idx_q   <= IW'((32'd1 << dec_lvl) - 32'd1);
						state_q <= S_A_RD;
					end else begin
						idx_q   <= dec_idx;
						state_q <= S_F_RD;
					end
				end
				S_A_RD: state_q <= S_A_CHK;
				S_A_CHK: begin
					if (rdata == NS_FREE) begin
						state_q <= (lvl_q == lr_q) ? S_A_USE : S_A_SPL;
					end else if (idx_q == lvl_last) begin
						// level exhausted: move one level up, or give up at the root
						if (lvl_q == '0) begin
							stat_q  <= ST_NOFIT;
							state_q <= S_DONE;
						end else begin
							lvl_q   <= lvl_q - 1'b1;
							idx_q   <= base_dn;
							state_q <= S_A_RD;
						end
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_A_RD;
					end
				end
				S_A_SPL: state_q <= S_A_SPR;
				S_A_SPR: begin
					// keep the lower half
					idx_q   <= {idx_q[IW-2:0], 1'b1};
					lvl_q   <= lvl_q + 1'b1;
					state_q <= (lvl_q + 1'b1 == lr_q) ? S_A_USE : S_A_SPL;
				end
				S_A_USE: begin
					stat_q  <= ST_OK;
					start_q <= start32[START_W-1:0];
					state_q <= S_DONE;
				end
				S_F_RD: state_q <= S_F_CHK;
				S_F_CHK: begin
					if (rdata == NS_FREE || rdata == NS_USED) begin
						state_q <= S_F_WFR;
					end else begin
						stat_q  <= ST_NOTFOUND;
						state_q <= S_DONE;
					end
				end
				S_F_WFR: begin
					stat_q  <= ST_OK;
					state_q <= (idx_q == '0) ? S_DONE : S_F_BRD;
				end
				S_F_BRD: state_q <= S_F_BCK;
				S_F_BCK: state_q <= (rdata == NS_FREE) ? S_F_M1 : S_DONE;
				S_F_M1: state_q <= S_F_M2;
				S_F_M2: state_q <= S_F_M3;
				S_F_M3: begin
					idx_q   <= parent;
					state_q <= (parent == '0) ? S_DONE : S_F_BRD;
				end
				S_DONE: begin
					// hold until the result register is free
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.status        <= stat_q;
						rsp_q.granted_start <= start_q;
						rsp_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a failed request never reports a start
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK |-> rsp_data.granted_start == '0)
		else $error("granted start set on a failed request");

	// one transfer in makes the block busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// no request during the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !req_ready)
		else $error("ready during clearing pass");

endmodule
